@@ design/rpl_pkg.sv @@
`default_nettype none
package rpl_pkg;
   localparam int MaxEntries = 1024;
   localparam int NumTables = 2;
   localparam int TblW = $clog2(NumTables);
   localparam int IdxW = $clog2(MaxEntries);
   localparam int CntW = IdxW + 1;
   localparam int AddrW = TblW + IdxW;
   localparam int Depth = NumTables * MaxEntries;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_HASH = 2'd2;
   localparam logic [1:0] CMD_RANGE = 2'd3;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NOT_READY = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL = 2'd3;

   typedef struct packed {
      logic [1:0] cmd;
      logic table_select;
      logic [63:0] key;
      logic [30:0] boundary_or_owner;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [30:0] owner;
      logic [30:0] range_begin;
      logic [30:0] range_end;
   } rsp_type;
endpackage
`default_nettype wire

@@ design/rpl_modulo.sv @@
`default_nettype none
module rpl_modulo import rpl_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic [63:0] dividend,
   input wire logic [30:0] divisor,
   output logic done,
   output logic [30:0] remainder
);
   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [30:0] div_ff, div_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [32:0] trial;

   // One restoring step per cycle: shift in a dividend bit, subtract if it fits.
   assign trial = {rem_ff, quo_ff[63]} - {2'b00, div_ff};
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[62:0], 1'b0};
         if (!trial[32]) rem_in = trial[31:0];
         else rem_in = {rem_ff[30:0], quo_ff[63]};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end
   assign done = busy_ff && (cnt_ff == 7'd1);
   assign remainder = (!trial[32]) ? trial[30:0] : {rem_ff[29:0], quo_ff[63]};
endmodule
`default_nettype wire

@@ design/range_partition_lookup_core.sv @@
// Channel  | Direction | Handshake
// req_*    | in        | req_valid / req_stall
// rsp_*    | out       | rsp_valid / rsp_stall
// Clear zeroes the table's entry count. Insert shifts each larger entry up one
// slot, one entry per read/write pair (S_INS_RD, then S_INS_CHK). Hash lookup
// runs the bit-serial modulo and then a linear scan of the table.
// Range lookup scans linearly, one entry per cycle. Reset is synchronous and
// empties both tables. A stalled result holds and the block takes no request.
`default_nettype none
module range_partition_lookup_core import rpl_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output rsp_type rsp_data
);
   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_INS_RD = 7'b0000010,
      S_INS_CHK = 7'b0000100,
      S_LARGE = 7'b0001000,
      S_MOD = 7'b0010000,
      S_SCAN = 7'b0100000,
      S_OUT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [30:0] mem [Depth];
   logic [30:0] rd_ff;
   logic [AddrW-1:0] rd_addr;
   logic rd_en, wr_en;
   logic [AddrW-1:0] wr_addr;
   logic [30:0] wr_data;

   logic [CntW-1:0] count_ff [NumTables];
   logic [CntW-1:0] count_in [NumTables];
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic [30:0] prev_ff, prev_in, target_ff, target_in;
   logic mod_start, mod_done;
   logic [30:0] mod_rem;
   logic [TblW-1:0] tsel;
   logic [CntW-1:0] cnt;

   // Table index from the held request; wraps modulo the table count.
   assign tsel = TblW'(32'(req_ff.table_select) % NumTables);
   assign cnt = count_ff[tsel];

   // Boundary store, one read and one write port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   rpl_modulo u_mod (
      .clock(clock), .reset(reset), .start(mod_start),
      .dividend(req_ff.key), .divisor(rd_ff),
      .done(mod_done), .remainder(mod_rem)
   );

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      pos_in = pos_ff;
      prev_in = prev_ff;
      target_in = target_ff;
      count_in = count_ff;
      rd_en = 1'b0;
      rd_addr = {tsel, IdxW'(0)};
      wr_en = 1'b0;
      wr_addr = {tsel, IdxW'(0)};
      wr_data = req_ff.boundary_or_owner;
      mod_start = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               state_in = S_OUT;
               rsp_in = '0;
               pos_in = '0;
               prev_in = '0;
               target_in = req_data.boundary_or_owner;
               case (req_data.cmd)
                  CMD_CLEAR: begin
                     count_in[TblW'(32'(req_data.table_select) % NumTables)] = '0;
                  end
                  CMD_INSERT: begin
                     if (count_ff[TblW'(32'(req_data.table_select) % NumTables)]
                         >= CntW'(MaxEntries))
                        rsp_in.status = ST_FULL;
                     else begin
                        pos_in = count_ff[TblW'(32'(req_data.table_select) % NumTables)];
                        state_in = S_INS_RD;
                     end
                  end
                  default: begin
                     // A range lookup reads entry zero now so the scan starts with it.
                     if (req_data.cmd == CMD_RANGE) begin
                        rd_en = 1'b1;
                        rd_addr = {TblW'(32'(req_data.table_select) % NumTables),
                                   IdxW'(0)};
                     end
                     if (count_ff[TblW'(32'(req_data.table_select) % NumTables)] == '0)
                        rsp_in.status = ST_NOT_READY;
                     else if (req_data.cmd == CMD_HASH) state_in = S_LARGE;
                     else state_in = S_SCAN;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            // pos is the empty slot; read the entry before it.
            if (pos_ff == '0) begin
               wr_en = 1'b1;
               wr_addr = {tsel, IdxW'(0)};
               count_in[tsel] = cnt + CntW'(1);
               state_in = S_OUT;
            end else begin
               rd_en = 1'b1;
               rd_addr = {tsel, pos_ff[IdxW-1:0] - IdxW'(1)};
               state_in = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            wr_en = 1'b1;
            wr_addr = {tsel, pos_ff[IdxW-1:0]};
            if (rd_ff > req_ff.boundary_or_owner) begin
               wr_data = rd_ff;
               pos_in = pos_ff - CntW'(1);
               state_in = S_INS_RD;
            end else begin
               count_in[tsel] = cnt + CntW'(1);
               state_in = S_OUT;
            end
         end
         S_LARGE: begin
            // Fetch the largest boundary, then start the modulo on it (not ready if it is zero).
            if (pos_ff == '0) begin
               rd_en = 1'b1;
               rd_addr = {tsel, IdxW'(cnt - CntW'(1))};
               pos_in = CntW'(1);
            end else if (rd_ff == '0) begin
               rsp_in.status = ST_NOT_READY;
               state_in = S_OUT;
            end else begin
               mod_start = 1'b1;
               target_in = rd_ff;
               pos_in = '0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               if (mod_rem != '0) target_in = mod_rem;
               rd_en = 1'b1;
               rd_addr = {tsel, IdxW'(0)};
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // Each cycle checks the entry already read and reads the next one.
            rd_en = 1'b1;
            rd_addr = {tsel, IdxW'(pos_ff + CntW'(1))};
            if (req_ff.cmd == CMD_HASH ? (rd_ff >= target_ff)
                                       : (rd_ff == target_ff)) begin
               rsp_in.status = ST_OK;
               rsp_in.owner = rd_ff;
               rsp_in.range_begin = prev_ff;
               rsp_in.range_end = rd_ff;
               state_in = S_OUT;
            end else if (pos_ff + CntW'(1) >= cnt) begin
               rsp_in.status = ST_NOT_FOUND;
               state_in = S_OUT;
            end else begin
               prev_in = rd_ff;
               pos_in = pos_ff + CntW'(1);
            end
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < NumTables; i++) count_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      pos_ff <= pos_in;
      prev_ff <= prev_in;
      target_ff <= target_in;
   end

   // The block takes a request only when idle and shows a result in S_OUT.
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

@@ bench/tb_range_partition_lookup_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_range_partition_lookup_core;
   import rpl_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;

   range_partition_lookup_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   // Shadow copy of the partition tables.
   logic [30:0] shadow_bounds [NumTables][MaxEntries];
   int shadow_count [NumTables];

   rsp_type pending_rsp [$];
   int fail_count = 0;
   int row_fail_count = 0;
   longint cycle_count = 0;
   logic stall_gen_on = 1'b1;

   // A directed row: the request and, where known, the typed-in result.
   typedef struct {
      logic [1:0] cmd;
      logic tbl;
      logic [63:0] key;
      logic [30:0] val;
      bit fixed;
      rsp_type want;
   } row_type;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 64'd10000000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic rsp_type mk_rsp(logic [1:0] s, logic [30:0] o, logic [30:0] b,
                                      logic [30:0] e);
      rsp_type r;
      r.status = s;
      r.owner = o;
      r.range_begin = b;
      r.range_end = e;
      return r;
   endfunction

   // Compute the result of a request and update the shadow tables.
   function automatic rsp_type partition_result(req_type q);
      int t;
      int n;
      int pos;
      logic [30:0] prev;
      logic [30:0] largest;
      logic [63:0] rem;
      t = q.table_select;
      n = shadow_count[t];
      prev = '0;
      case (q.cmd)
         CMD_CLEAR: begin
            shadow_count[t] = 0;
            return mk_rsp(ST_OK, 0, 0, 0);
         end
         CMD_INSERT: begin
            if (n >= MaxEntries) return mk_rsp(ST_FULL, 0, 0, 0);
            pos = n;
            while (pos > 0 && shadow_bounds[t][pos-1] > q.boundary_or_owner) begin
               shadow_bounds[t][pos] = shadow_bounds[t][pos-1];
               pos--;
            end
            shadow_bounds[t][pos] = q.boundary_or_owner;
            shadow_count[t] = n + 1;
            return mk_rsp(ST_OK, 0, 0, 0);
         end
         CMD_HASH: begin
            if (n == 0) return mk_rsp(ST_NOT_READY, 0, 0, 0);
            largest = shadow_bounds[t][n-1];
            if (largest == 0) return mk_rsp(ST_NOT_READY, 0, 0, 0);
            rem = q.key % {33'd0, largest};
            if (rem == 0) rem = {33'd0, largest};
            for (int i = 0; i < n; i++) begin
               if ({33'd0, shadow_bounds[t][i]} >= rem)
                  return mk_rsp(ST_OK, shadow_bounds[t][i], prev, shadow_bounds[t][i]);
               prev = shadow_bounds[t][i];
            end
            return mk_rsp(ST_NOT_FOUND, 0, 0, 0);
         end
         default: begin
            if (n == 0) return mk_rsp(ST_NOT_READY, 0, 0, 0);
            for (int i = 0; i < n; i++) begin
               if (shadow_bounds[t][i] == q.boundary_or_owner)
                  return mk_rsp(ST_OK, q.boundary_or_owner, prev, q.boundary_or_owner);
               prev = shadow_bounds[t][i];
            end
            return mk_rsp(ST_NOT_FOUND, 0, 0, 0);
         end
      endcase
   endfunction

   // Random stall on the result side, with stretches of none.
   always @(posedge clock) begin
      if (reset || !stall_gen_on) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
         rsp_stall <= 1'b1;
      end else if (rsp_stall && $urandom_range(0, 99) < 10) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 25) && (cycle_count[12:11] != 2'b00);
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result %p", rsp_data);
            fail_count++;
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_data.status !== w.status) begin
               $error("status: expected %0d, actual %0d", w.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.owner !== w.owner) begin
               $error("owner: expected %0d, actual %0d", w.owner, rsp_data.owner);
               fail_count++;
            end
            if (rsp_data.range_begin !== w.range_begin) begin
               $error("range_begin: expected %0d, actual %0d", w.range_begin,
                      rsp_data.range_begin);
               fail_count++;
            end
            if (rsp_data.range_end !== w.range_end) begin
               $error("range_end: expected %0d, actual %0d", w.range_end,
                      rsp_data.range_end);
               fail_count++;
            end
         end
      end
   end

   // Present one request, wait for acceptance, record its expected result.
   task automatic send_request(req_type q, bit fixed, rsp_type want);
      rsp_type p;
      int gap;
      p = partition_result(q);
      if (fixed && p !== want) begin
         $error("table row: expected %p, predicted %p", want, p);
         row_fail_count++;
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(fixed ? want : p);
      gap = ($urandom_range(0, 9) < 7) ? 0 : (($urandom_range(0, 9) < 8) ?
            $urandom_range(1, 4) : $urandom_range(10, 60));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic req_type mk_req(logic [1:0] c, logic t, logic [63:0] k,
                                      logic [30:0] v);
      req_type q;
      q.cmd = c;
      q.table_select = t;
      q.key = k;
      q.boundary_or_owner = v;
      return q;
   endfunction

   row_type directed_rows [$];

   function automatic void add_row(logic [1:0] c, logic t, logic [63:0] k, logic [30:0] v,
                                   bit fx, rsp_type w);
      row_type r;
      r.cmd = c;
      r.tbl = t;
      r.key = k;
      r.val = v;
      r.fixed = fx;
      r.want = w;
      directed_rows.push_back(r);
   endfunction

   // Stimulus: directed rows, a full-table fill, then mostly clear-then-fill-then-query sequences.
   initial begin
      rsp_type none;
      req_type q;
      int sent;
      int fill;
      int mode;
      logic [30:0] v;
      logic [63:0] k;
      none = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      for (int t = 0; t < NumTables; t++) shadow_count[t] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty tables, extremes, zero boundary, duplicates.
      add_row(CMD_HASH, 0, 64'd5, 0, 1, mk_rsp(ST_NOT_READY, 0, 0, 0));
      add_row(CMD_RANGE, 1, 0, 31'd7, 1, mk_rsp(ST_NOT_READY, 0, 0, 0));
      add_row(CMD_INSERT, 0, 0, 31'd0, 1, mk_rsp(ST_OK, 0, 0, 0));
      add_row(CMD_HASH, 0, '1, 0, 1, mk_rsp(ST_NOT_READY, 0, 0, 0));
      add_row(CMD_RANGE, 0, 0, 31'd0, 1, mk_rsp(ST_OK, 0, 0, 0));
      add_row(CMD_INSERT, 0, '1, 31'h7FFFFFFF, 1, mk_rsp(ST_OK, 0, 0, 0));
      add_row(CMD_INSERT, 0, 0, 31'd100, 1, mk_rsp(ST_OK, 0, 0, 0));
      add_row(CMD_INSERT, 0, 0, 31'd100, 1, mk_rsp(ST_OK, 0, 0, 0));
      add_row(CMD_HASH, 0, 64'hFFFFFFFFFFFFFFFF, 0, 0, none);
      add_row(CMD_HASH, 0, 64'd0, 0, 0, none);
      add_row(CMD_HASH, 0, 64'd50, 0, 0, none);
      add_row(CMD_HASH, 0, 64'h7FFFFFFF, 0, 0, none);
      add_row(CMD_RANGE, 0, 0, 31'h7FFFFFFF, 0, none);
      add_row(CMD_RANGE, 0, 0, 31'd100, 0, none);
      add_row(CMD_RANGE, 0, 0, 31'd55, 1, mk_rsp(ST_NOT_FOUND, 0, 0, 0));
      add_row(CMD_INSERT, 1, 64'h5555555555555555, 31'h2AAAAAAA, 1, mk_rsp(ST_OK, 0, 0, 0));
      add_row(CMD_HASH, 1, 64'hAAAAAAAAAAAAAAAA, 31'h55555555, 0, none);
      add_row(CMD_CLEAR, 0, 0, 0, 1, mk_rsp(ST_OK, 0, 0, 0));
      add_row(CMD_RANGE, 0, 0, 31'd100, 1, mk_rsp(ST_NOT_READY, 0, 0, 0));
      add_row(CMD_CLEAR, 1, '1, '1, 1, mk_rsp(ST_OK, 0, 0, 0));
      foreach (directed_rows[i])
         send_request(mk_req(directed_rows[i].cmd, directed_rows[i].tbl,
                             directed_rows[i].key, directed_rows[i].val),
                      directed_rows[i].fixed, directed_rows[i].want);

      // Fill table 0 to the limit once to reach the full-table case.
      stall_gen_on = 1'b0;
      for (int i = 0; i < MaxEntries; i++)
         send_request(mk_req(CMD_INSERT, 0, 64'($urandom), 31'($urandom_range(0, 4999))),
                      0, none);
      send_request(mk_req(CMD_INSERT, 0, 0, 31'd9), 1, mk_rsp(ST_FULL, 0, 0, 0));
      for (int i = 0; i < 4; i++)
         send_request(mk_req(CMD_HASH, 0, {$urandom, $urandom}, 0), 0, none);
      send_request(mk_req(CMD_CLEAR, 0, 0, 0), 1, mk_rsp(ST_OK, 0, 0, 0));
      stall_gen_on = 1'b1;

      sent = 0;
      while (sent < 500) begin
         mode = $urandom_range(0, 9);
         if (mode < 8) begin
            q = mk_req(CMD_CLEAR, 1'($urandom_range(0, 1)), {$urandom, $urandom},
                       31'($urandom));
            send_request(q, 0, none);
            fill = $urandom_range(1, 12);
            for (int i = 0; i < fill; i++) begin
               v = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 300));
               send_request(mk_req(CMD_INSERT, q.table_select, {$urandom, $urandom}, v),
                            0, none);
            end
            for (int i = 0; i < 6; i++) begin
               k = {$urandom, $urandom};
               if ($urandom_range(0, 1))
                  v = shadow_bounds[q.table_select][$urandom_range(0,
                      shadow_count[q.table_select] - 1)];
               else
                  v = 31'($urandom);
               send_request(mk_req($urandom_range(0, 1) ? CMD_HASH : CMD_RANGE,
                                   q.table_select, k, v), 0, none);
            end
            sent += fill + 7;
         end else begin
            // Noise: any command on either table.
            q = mk_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       {$urandom, $urandom}, 31'($urandom));
            if (q.cmd == CMD_INSERT && shadow_count[q.table_select] >= MaxEntries)
               q.cmd = CMD_CLEAR;
            send_request(q, 0, none);
            sent++;
         end
      end
      req_valid <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && row_fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
